/* design/adspf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package adspf_pkg;

    // default sizing
    localparam int REPORT_MAX_BYTES_DEF = 31;
    localparam int PAYLOAD_BYTES_DEF    = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AD_TYPE      = 2'd0,
        CFG_COMPANY_ID   = 2'd1,
        CFG_NODE_ADDRESS = 2'd2
    } cfg_reg_t;

    // register reset values
    localparam logic [7:0]  AD_TYPE_RST      = 8'hFF;
    localparam logic [15:0] COMPANY_ID_RST   = 16'h0059;
    localparam logic [7:0]  NODE_ADDRESS_RST = 8'h00;

    // data bytes of the matched structure ahead of the payload
    localparam int HEAD_BYTES = 3;

endpackage

`default_nettype wire

/* design/ad_structure_payload_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake             word
// -------   ---------  --------------------  -----------------------------------------------
// in        input      in_valid / in_ready   data_byte, end_of_report
// out       output     out_valid / out_ready accepted, payload_byte, byte_position, last_result
// cfg       input      cfg_we (no wait)      cfg_index, cfg_data
//
// one word is taken per cycle while in_ready is high; it is parsed from the input register
// at report end the result burst is PAYLOAD_BYTES words (match) or one word (no match),
// drained one word per cycle unless out stalls, from a burst buffer as the next report is parsed
// a new report end waits in the input register only while the previous burst still drains
// rst_n clears parser, burst control and valid flags; payload bytes are not reset
// a stall on out holds the output register and, once the burst buffer is busy, the next end word

module ad_structure_payload_filter_top
    import adspf_pkg::*;
#(
    parameter int REPORT_MAX_BYTES = REPORT_MAX_BYTES_DEF,
    parameter int PAYLOAD_BYTES    = PAYLOAD_BYTES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            data_byte,
    input  wire logic                  end_of_report,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       accepted,
    output logic [7:0]                 payload_byte,
    output logic [3:0]                 byte_position,
    output logic                       last_result,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // widths that follow from the parameters
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int DP_W  = $clog2(PAYLOAD_BYTES + HEAD_BYTES + 1);
    localparam int RP_W  = $clog2(REPORT_MAX_BYTES + 1);

    localparam logic [7:0]       STRUCT_LEN  = 8'(PAYLOAD_BYTES + HEAD_BYTES + 1);
    localparam logic [DP_W-1:0]  DP_LAST     = DP_W'(PAYLOAD_BYTES + HEAD_BYTES);
    localparam logic [DP_W-1:0]  DP_HEAD     = DP_W'(HEAD_BYTES);
    localparam logic [RP_W-1:0]  RP_MAX      = RP_W'(REPORT_MAX_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(PAYLOAD_BYTES - 1);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_TYPE,
        PH_SKIP,
        PH_COLLECT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_ACCEPT,
        OUT_REJECT
    } outcome_t;

    // configuration registers
    logic [7:0]  ad_type_reg;
    logic [15:0] company_id_reg;
    logic [7:0]  node_address_reg;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // parser state
    phase_t          phase_reg,  phase_next;
    logic [7:0]      flen_reg,   flen_next;
    logic [7:0]      left_reg,   left_next;
    logic [DP_W-1:0] dpos_reg,   dpos_next;
    logic [RP_W-1:0] rpos_reg,   rpos_next;
    outcome_t        outcome_reg, outcome_next;

    // payload store and burst buffer
    logic [7:0] store_reg [PAYLOAD_BYTES];
    logic [7:0] burst_reg [PAYLOAD_BYTES];

    // burst control
    logic             burst_active_reg;
    logic             burst_match_reg;
    logic [IDX_W-1:0] burst_idx_reg;

    // output register
    logic       out_valid_reg;
    logic       accepted_reg;
    logic [7:0] payload_byte_reg;
    logic [3:0] byte_position_reg;
    logic       last_result_reg;

    logic             s1_go;
    logic             s1_take;
    logic             s1_end;
    logic             take_byte;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             out_load;
    logic             burst_last;
    logic             head_ok;

    // an end word may only leave the input register when the burst buffer is free
    assign s1_go    = !s1_last_reg || !burst_active_reg;
    assign s1_take  = s1_valid_reg && s1_go;
    assign s1_end   = s1_take && s1_last_reg;
    assign in_ready = !s1_valid_reg || s1_go;

    // bytes past the maximum report length are not parsed
    assign take_byte = rpos_reg < RP_MAX;

    assign wr_idx = IDX_W'(dpos_reg - DP_HEAD);

    // parse one byte
    always_comb
    begin
        phase_next   = phase_reg;
        flen_next    = flen_reg;
        left_next    = left_reg;
        dpos_next    = dpos_reg;
        outcome_next = outcome_reg;
        rpos_next    = rpos_reg;
        wr_en        = 1'b0;
        head_ok      = 1'b1;
        if (take_byte)
        begin
            rpos_next = rpos_reg + RP_W'(1);
            case (phase_reg)
                PH_LEN:
                begin
                    // a zero length byte has no type byte behind it
                    if (s1_byte_reg != 8'd0)
                    begin
                        flen_next  = s1_byte_reg;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    if (s1_byte_reg == ad_type_reg)
                    begin
                        if (flen_reg == STRUCT_LEN)
                        begin
                            dpos_next  = '0;
                            phase_next = PH_COLLECT;
                        end
                        else
                        begin
                            outcome_next = OUT_REJECT;
                            phase_next   = PH_DONE;
                        end
                    end
                    else
                    begin
                        left_next  = flen_reg - 8'd1;
                        phase_next = (flen_reg != 8'd1) ? PH_SKIP : PH_LEN;
                    end
                end
                PH_SKIP:
                begin
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_COLLECT:
                begin
                    if (dpos_reg == DP_W'(0))
                    begin
                        head_ok = s1_byte_reg == company_id_reg[7:0];
                    end
                    else if (dpos_reg == DP_W'(1))
                    begin
                        head_ok = s1_byte_reg == company_id_reg[15:8];
                    end
                    else if (dpos_reg == DP_W'(2))
                    begin
                        head_ok = s1_byte_reg == node_address_reg;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                    if (!head_ok)
                    begin
                        outcome_next = OUT_REJECT;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        dpos_next = dpos_reg + DP_W'(1);
                        if (dpos_reg + DP_W'(1) >= DP_LAST)
                        begin
                            outcome_next = OUT_ACCEPT;
                            phase_next   = PH_DONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // burst output
    assign out_load   = burst_active_reg && (!out_valid_reg || out_ready);
    assign burst_last = !burst_match_reg || (burst_idx_reg == IDX_LAST);

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ad_type_reg       <= AD_TYPE_RST;
            company_id_reg    <= COMPANY_ID_RST;
            node_address_reg  <= NODE_ADDRESS_RST;
            s1_valid_reg      <= 1'b0;
            phase_reg         <= PH_LEN;
            flen_reg          <= '0;
            left_reg          <= '0;
            dpos_reg          <= '0;
            rpos_reg          <= '0;
            outcome_reg       <= OUT_NONE;
            burst_active_reg  <= 1'b0;
            burst_match_reg   <= 1'b0;
            burst_idx_reg     <= '0;
            out_valid_reg     <= 1'b0;
            accepted_reg      <= 1'b0;
            payload_byte_reg  <= '0;
            byte_position_reg <= '0;
            last_result_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_AD_TYPE:      ad_type_reg      <= cfg_data[7:0];
                    CFG_COMPANY_ID:   company_id_reg   <= cfg_data;
                    CFG_NODE_ADDRESS: node_address_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (s1_take)
            begin
                if (s1_last_reg)
                begin
                    // report over: start a fresh parse
                    phase_reg   <= PH_LEN;
                    flen_reg    <= '0;
                    left_reg    <= '0;
                    dpos_reg    <= '0;
                    rpos_reg    <= '0;
                    outcome_reg <= OUT_NONE;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    flen_reg    <= flen_next;
                    left_reg    <= left_next;
                    dpos_reg    <= dpos_next;
                    rpos_reg    <= rpos_next;
                    outcome_reg <= outcome_next;
                end
            end

            if (s1_end)
            begin
                burst_active_reg <= 1'b1;
                burst_match_reg  <= outcome_next == OUT_ACCEPT;
                burst_idx_reg    <= '0;
            end
            else if (out_load)
            begin
                burst_idx_reg <= burst_idx_reg + IDX_W'(1);
                if (burst_last)
                begin
                    burst_active_reg <= 1'b0;
                end
            end

            if (out_load)
            begin
                out_valid_reg   <= 1'b1;
                accepted_reg    <= burst_match_reg;
                last_result_reg <= burst_last;
                if (burst_match_reg)
                begin
                    payload_byte_reg  <= burst_reg[burst_idx_reg];
                    byte_position_reg <= 4'(burst_idx_reg);
                end
                else
                begin
                    payload_byte_reg  <= '0;
                    byte_position_reg <= '0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload path, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= end_of_report;
        end
        if (s1_take && wr_en)
        begin
            store_reg[wr_idx] <= s1_byte_reg;
        end
        // snapshot the store into the burst buffer, with the byte written this cycle
        if (s1_end)
        begin
            for (int k = 0; k < PAYLOAD_BYTES; k++)
            begin
                burst_reg[k] <= (wr_en && (wr_idx == IDX_W'(k))) ? s1_byte_reg : store_reg[k];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = accepted_reg;
    assign payload_byte  = payload_byte_reg;
    assign byte_position = byte_position_reg;
    assign last_result   = last_result_reg;

endmodule

`default_nettype wire

/* design/adspf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module adspf_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       accepted,
    input wire logic [7:0] payload_byte,
    input wire logic [3:0] byte_position,
    input wire logic       last_result
);

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(accepted)
            && $stable(payload_byte) && $stable(byte_position) && $stable(last_result))
    else $error("output word changed under stall");

    // a no-match word stands alone and is blank
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> last_result && payload_byte == 8'd0
            && byte_position == 4'd0)
    else $error("malformed no-match word");

    // payload burst runs without gaps and in order
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && accepted && !last_result |=> out_valid && accepted
            && byte_position == 4'($past(byte_position) + 4'd1))
    else $error("payload burst broken");

endmodule

bind ad_structure_payload_filter_top adspf_checker u_adspf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .payload_byte  (payload_byte),
    .byte_position (byte_position),
    .last_result   (last_result)
);

`default_nettype wire

/* test/tb_ad_structure_payload_filter_top.sv */
`timescale 1ns / 1ps

module tb_ad_structure_payload_filter_top;
    import adspf_pkg::*;

    localparam int         PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
    localparam int         REPORT_MAX    = REPORT_MAX_BYTES_DEF;
    // length byte of the wanted structure: type, company id, node address, payload
    localparam logic [7:0] STRUCT_LEN    = 8'(PAYLOAD_BYTES + HEAD_BYTES + 1);
    localparam int         DRAIN_CYCLES  = 12;
    localparam int         CYCLE_LIMIT   = 400000;

    // parser phases of the local copy
    typedef enum logic [2:0] {
        SEEK_LEN,
        SEEK_TYPE,
        SKIP_DATA,
        COLLECT,
        DECIDED
    } parse_phase_t;

    typedef enum logic [1:0] {
        NOT_FOUND,
        MATCHED,
        REJECTED
    } outcome_t;

    // ways a generated report departs from a clean match
    typedef enum int {
        FLAW_NONE,
        FLAW_LEN,
        FLAW_CID_LO,
        FLAW_CID_HI,
        FLAW_NODE,
        FLAW_TRUNC,
        FLAW_NOISE
    } flaw_t;

    typedef struct packed {
        logic       accepted;
        logic [7:0] payload;
        logic [3:0] position;
        logic       is_last;
    } result_word_t;

    typedef logic [7:0] octet_q_t [$];

    // clock, reset and block ports
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte     = 8'h00;
    logic                  end_of_report = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic                  accepted;
    logic [7:0]            payload_byte;
    logic [3:0]            byte_position;
    logic                  last_result;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // traffic shaping, percentages of cycles
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    int error_count = 0;
    int cycle_count = 0;

    // local copy of the registers
    logic [7:0]  want_type;
    logic [15:0] want_company;
    logic [7:0]  want_node;

    // local copy of the parser
    parse_phase_t phase;
    outcome_t     outcome;
    logic [7:0]   skip_left;
    logic [7:0]   seen_len;
    logic [7:0]   data_pos;
    int           bytes_seen;
    logic [7:0]   payload_copy [PAYLOAD_BYTES];

    result_word_t expected_results [$];
    octet_q_t     report_bytes;

    ad_structure_payload_filter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_report (end_of_report),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .accepted      (accepted),
        .payload_byte  (payload_byte),
        .byte_position (byte_position),
        .last_result   (last_result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // expected-result prediction
    // ---------------------------------------------------------------

    task automatic clear_parse();
        phase      = SEEK_LEN;
        outcome    = NOT_FOUND;
        skip_left  = 8'h00;
        seen_len   = 8'h00;
        data_pos   = 8'h00;
        bytes_seen = 0;
    endtask

    task automatic reset_model();
        want_type    = AD_TYPE_RST;
        want_company = COMPANY_ID_RST;
        want_node    = NODE_ADDRESS_RST;
        clear_parse();
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            payload_copy[k] = 8'h00;
    endtask

    // one byte through the structure walker
    task automatic parse_byte(input logic [7:0] b);
        logic ok;
        int   p;
        ok = 1'b1;
        p  = data_pos;
        case (phase)
            SEEK_LEN:
                // a zero length byte is a structure with no type; look for the next length
                if (b != 8'h00)
                begin
                    seen_len = b;
                    phase    = SEEK_TYPE;
                end
            SEEK_TYPE:
                if (b == want_type)
                begin
                    if (seen_len == STRUCT_LEN)
                    begin
                        data_pos = 8'h00;
                        phase    = COLLECT;
                    end
                    else
                    begin
                        // right type, wrong size: search is over
                        outcome = REJECTED;
                        phase   = DECIDED;
                    end
                end
                else
                begin
                    skip_left = seen_len - 8'd1;
                    phase     = (skip_left != 8'h00) ? SKIP_DATA : SEEK_LEN;
                end
            SKIP_DATA:
            begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'h00)
                    phase = SEEK_LEN;
            end
            COLLECT:
            begin
                if (p == 0)
                    ok = (b == want_company[7:0]);
                else if (p == 1)
                    ok = (b == want_company[15:8]);
                else if (p == 2)
                    ok = (b == want_node);
                else
                    payload_copy[p - HEAD_BYTES] = b;
                if (!ok)
                begin
                    outcome = REJECTED;
                    phase   = DECIDED;
                end
                else
                begin
                    p++;
                    data_pos = 8'(p);
                    if (p >= PAYLOAD_BYTES + HEAD_BYTES)
                    begin
                        outcome = MATCHED;
                        phase   = DECIDED;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    // called once per accepted input word
    task automatic predict_word(input logic [7:0] b, input logic eor);
        result_word_t w;
        // bytes past the report limit are dropped, only their end mark counts
        if (bytes_seen < REPORT_MAX)
        begin
            bytes_seen++;
            parse_byte(b);
        end
        if (eor)
        begin
            if (outcome == MATCHED)
            begin
                for (int k = 0; k < PAYLOAD_BYTES; k++)
                begin
                    w.accepted = 1'b1;
                    w.payload  = payload_copy[k];
                    w.position = 4'(k);
                    w.is_last  = (k == PAYLOAD_BYTES - 1);
                    expected_results.push_back(w);
                end
            end
            else
            begin
                w.accepted = 1'b0;
                w.payload  = 8'h00;
                w.position = 4'h0;
                w.is_last  = 1'b1;
                expected_results.push_back(w);
            end
            clear_parse();
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // every output word taken at an edge is compared with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected output word", payload_byte, 0);
            else
            begin
                exp_w = expected_results.pop_front();
                if (accepted !== exp_w.accepted)
                    report_mismatch("accepted", accepted, exp_w.accepted);
                if (payload_byte !== exp_w.payload)
                    report_mismatch("payload_byte", payload_byte, exp_w.payload);
                if (byte_position !== exp_w.position)
                    report_mismatch("byte_position", byte_position, exp_w.position);
                if (last_result !== exp_w.is_last)
                    report_mismatch("last_result", last_result, exp_w.is_last);
            end
        end
    end

    // receiver: a long hold-off when asked, else random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offer one word, wait for the handshake, then predict
    task automatic send_word(input logic [7:0] b, input logic eor);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_report <= eor;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_word(b, eor);
    endtask

    // the report built in report_bytes, end mark on its last byte
    task automatic send_report();
        for (int i = 0; i < report_bytes.size(); i++)
            send_word(report_bytes[i], i == report_bytes.size() - 1);
    endtask

    // pause the sender until every result is in and the block is quiet
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, only while idle; the caller drops the write enable
    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            CFG_AD_TYPE:      want_type    = value[7:0];
            CFG_COMPANY_ID:   want_company = value;
            CFG_NODE_ADDRESS: want_node    = value[7:0];
            default:          ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] t, input logic [15:0] cid, input logic [7:0] node);
        write_reg(CFG_AD_TYPE, {8'h00, t});
        write_reg(CFG_COMPANY_ID, cid);
        write_reg(CFG_NODE_ADDRESS, {8'h00, node});
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // report generation
    // ---------------------------------------------------------------

    function automatic logic [7:0] other_type();
        logic [7:0] t;
        do
            t = 8'($urandom_range(255));
        while (t == want_type);
        return t;
    endfunction

    // leading structures, the wanted structure, trailing bytes; flaw bends it
    task automatic build_report(input flaw_t flaw);
        int         n_pre;
        int         len;
        int         start;
        int         cut;
        logic [7:0] bad_len;
        report_bytes = {};
        if (flaw == FLAW_NOISE)
        begin
            // raw bytes, often past the report limit
            len = $urandom_range(1, 40);
            repeat (len) report_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            n_pre = $urandom_range(0, 3);
            repeat (n_pre)
            begin
                if ($urandom_range(3) == 0)
                    report_bytes.push_back(8'h00);
                else
                begin
                    len = $urandom_range(1, 3);
                    report_bytes.push_back(8'(len));
                    report_bytes.push_back(other_type());
                    repeat (len - 1) report_bytes.push_back(8'($urandom_range(255)));
                end
            end
            start = report_bytes.size();
            do
                bad_len = 8'($urandom_range(1, 255));
            while (bad_len == STRUCT_LEN);
            report_bytes.push_back((flaw == FLAW_LEN) ? bad_len : STRUCT_LEN);
            report_bytes.push_back(want_type);
            report_bytes.push_back(want_company[7:0]
                ^ ((flaw == FLAW_CID_LO) ? 8'($urandom_range(1, 255)) : 8'h00));
            report_bytes.push_back(want_company[15:8]
                ^ ((flaw == FLAW_CID_HI) ? 8'($urandom_range(1, 255)) : 8'h00));
            report_bytes.push_back(want_node
                ^ ((flaw == FLAW_NODE) ? 8'($urandom_range(1, 255)) : 8'h00));
            repeat (PAYLOAD_BYTES) report_bytes.push_back(8'($urandom_range(255)));
            if (flaw == FLAW_TRUNC)
            begin
                // end lands inside the wanted structure
                cut = $urandom_range(start + 1, start + STRUCT_LEN);
                while (report_bytes.size() > cut)
                    report_bytes.delete(report_bytes.size() - 1);
            end
            else
                // bytes after the decision are ignored
                repeat ($urandom_range(0, 3)) report_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // mostly clean reports with random content, the rest broken or noise
    task automatic random_reports(input int n_words);
        int    sent;
        flaw_t flaw;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(99) < 65)
                flaw = FLAW_NONE;
            else
                flaw = flaw_t'($urandom_range(FLAW_LEN, FLAW_NOISE));
            build_report(flaw);
            send_report();
            sent += report_bytes.size();
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // clean match at reset settings, payload extremes
    task automatic test_reset_defaults();
        idle_pct  = 0;
        stall_pct = 0;
        report_bytes = {STRUCT_LEN, AD_TYPE_RST, COMPANY_ID_RST[7:0], COMPANY_ID_RST[15:8],
                        NODE_ADDRESS_RST, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE};
        repeat (PAYLOAD_BYTES - 6) report_bytes.push_back(8'($urandom_range(255)));
        send_report();
    endtask

    // no-match paths, each as a short report
    task automatic test_special_cases();
        // zero length byte, then a skipped structure that ends the report
        report_bytes = {8'h00, 8'h02, 8'h10, 8'hAB};
        send_report();
        // report ends inside a skipped structure
        report_bytes = {8'h05, 8'h01, 8'h33};
        send_report();
        // wanted type with the wrong length, byte after the decision
        report_bytes = {8'h07, AD_TYPE_RST, STRUCT_LEN};
        send_report();
        // company id differs
        report_bytes = {STRUCT_LEN, AD_TYPE_RST, 8'h58};
        send_report();
        // node address differs
        report_bytes = {STRUCT_LEN, AD_TYPE_RST, 8'h59, 8'h00, 8'h01};
        send_report();
        // end inside the wanted structure
        report_bytes = {STRUCT_LEN, AD_TYPE_RST, 8'h59, 8'h00, 8'h00, 8'hAA};
        send_report();
    endtask

    // all-ones and all-zeros extremes, sender idling
    task automatic test_extreme_settings();
        wait_drained();
        write_all(8'h00, 16'hFFFF, 8'hFF);
        idle_pct  = 74;
        stall_pct = 0;
        random_reports(65);
    endtask

    // random settings, receiver stalling
    task automatic test_random_settings();
        wait_drained();
        write_all(8'($urandom_range(255)), 16'($urandom_range(65535)), 8'($urandom_range(255)));
        idle_pct  = 0;
        stall_pct = 74;
        random_reports(65);
    endtask

    // top type value, zero id and node, both sides idling
    task automatic test_low_settings();
        wait_drained();
        write_all(8'hFF, 16'h0000, 8'h00);
        idle_pct  = 28;
        stall_pct = 28;
        random_reports(65);
    endtask

    // long receiver hold-off with the sender pushing, then a full pause
    task automatic test_backpressure();
        wait_drained();
        write_all(8'($urandom_range(255)), 16'($urandom_range(65535)), 8'($urandom_range(255)));
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 300;
        repeat (4)
        begin
            build_report(FLAW_NONE);
            send_report();
        end
        wait_drained();
        build_report(FLAW_NONE);
        send_report();
    endtask

    // back to default settings, no idling
    task automatic test_mixed_no_idle();
        wait_drained();
        write_all(AD_TYPE_RST, COMPANY_ID_RST, NODE_ADDRESS_RST);
        idle_pct  = 0;
        stall_pct = 0;
        random_reports(65);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        reset_model();
        @(posedge clk);
        test_reset_defaults();
        test_special_cases();
        test_extreme_settings();
        test_random_settings();
        test_low_settings();
        test_backpressure();
        test_mixed_no_idle();
        wait_drained();
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
